### sv/rau_pkg.sv
// rau_pkg: shared types and codes for the rational arithmetic unit.
// Used by rau_ctrl, rau_datapath, rational_arith_unit and rau_checker.
package rau_pkg;

   localparam logic [1:0] CMD_ADD = 2'd0;
   localparam logic [1:0] CMD_SUB = 2'd1;
   localparam logic [1:0] CMD_MUL = 2'd2;
   localparam logic [1:0] CMD_DIV = 2'd3;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_DIV_ZERO = 2'd1;
   localparam logic [1:0] STAT_OVERFLOW = 2'd2;

   localparam logic [1:0] MSTEP_N0  = 2'd0;
   localparam logic [1:0] MSTEP_N1  = 2'd1;
   localparam logic [1:0] MSTEP_DEN = 2'd2;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] a_num;
      logic signed [31:0] a_den;
      logic signed [31:0] b_num;
      logic signed [31:0] b_den;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_num;
      logic signed [31:0] res_den;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic [1:0] mul_step;
      logic       combine;
      logic       gcd_init;
      logic       gcd_step;
      logic       g_load;
      logic       div_init;
      logic       div_step;
      logic       div_den;
      logic       emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic den_zero;
      logic gcd_done;
      logic div_last;
   } ctrl_stat_type;

endpackage

### sv/rational_arith_unit.sv
// rational_arith_unit: top level, exact fraction add/sub/mul/div with GCD reduction.
// Depends on rau_pkg, rau_ctrl and rau_datapath.
//
//   channel   ports                     direction   transfer
//   request   start, busy, req_data     in          start && !busy
//   response  rsp_valid, rsp_data       out         rsp_valid, one cycle
//
// Busy lasts through the cross products, the binary GCD loop and the shared
// restoring divider (two passes); a zero denominator skips the GCD and divider.
// The strobe follows the last busy cycle. One item in flight at a time.
// Synchronous reset clears the controller and the response strobe.
// The receiver cannot stall; each result is shown for one cycle.
module rational_arith_unit import rau_pkg::*; #(
   parameter int WORD_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   rau_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   rau_datapath #(
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### sv/rau_ctrl.sv
// rau_ctrl: sequencing state machine for the rational arithmetic unit.
// Depends on rau_pkg; drives rau_datapath through ctrl_cmd_type.
module rau_ctrl import rau_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  ctrl_stat_type stat,
   output ctrl_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MUL0  = 4'd1;
   localparam logic [3:0] S_MUL1  = 4'd2;
   localparam logic [3:0] S_MUL2  = 4'd3;
   localparam logic [3:0] S_COMB  = 4'd4;
   localparam logic [3:0] S_GINIT = 4'd5;
   localparam logic [3:0] S_GCD   = 4'd6;
   localparam logic [3:0] S_GFIN  = 4'd7;
   localparam logic [3:0] S_DIVN  = 4'd8;
   localparam logic [3:0] S_DINIT = 4'd9;
   localparam logic [3:0] S_DIVD  = 4'd10;
   localparam logic [3:0] S_DONE  = 4'd11;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_MUL0;
            end
         end
         S_MUL0: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_step = MSTEP_N0;
            state_in     = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_step = MSTEP_N1;
            state_in     = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_step = MSTEP_DEN;
            state_in     = S_COMB;
         end
         S_COMB: begin
            cmd.combine = 1'b1;
            state_in    = stat.den_zero ? S_DONE : S_GINIT;
         end
         S_GINIT: begin
            cmd.gcd_init = 1'b1;
            state_in     = S_GCD;
         end
         S_GCD: begin
            if (stat.gcd_done) begin
               state_in = S_GFIN;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_GFIN: begin
            cmd.g_load   = 1'b1;
            cmd.div_init = 1'b1;
            state_in     = S_DIVN;
         end
         S_DIVN: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = S_DINIT;
         end
         S_DINIT: begin
            cmd.div_init = 1'b1;
            cmd.div_den  = 1'b1;
            state_in     = S_DIVD;
         end
         S_DIVD: begin
            cmd.div_step = 1'b1;
            cmd.div_den  = 1'b1;
            if (stat.div_last) state_in = S_DONE;
         end
         S_DONE: begin
            cmd.emit = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### sv/rau_datapath.sv
// rau_datapath: cross products, binary GCD and restoring divider.
// Depends on rau_pkg; commanded by rau_ctrl.
module rau_datapath import rau_pkg::*; #(
   parameter int WORD_BITS = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  ctrl_cmd_type  cmd,
   output ctrl_stat_type stat,
   output logic          rsp_valid,
   output rsp_type       rsp_data
);

   localparam int MW = 2 * WORD_BITS;
   localparam int SW = $clog2(MW);

   // operands, sign-magnitude: 0 a_num, 1 a_den, 2 b_num, 3 b_den
   logic [1:0]           op_ff;
   logic [3:0]           sgn_ff;
   logic [WORD_BITS-1:0] mag_ff [4];
   logic [WORD_BITS-1:0] raw    [4];

   logic [MW-1:0] p0_mag_ff, p1_mag_ff, n_mag_ff, d_mag_ff;
   logic          p0_neg_ff, p1_neg_ff, n_neg_ff, d_neg_ff;
   logic [MW-1:0] u_ff, v_ff, g_ff, qn_ff, qd_ff, quot_ff;
   logic [MW:0]   rem_ff;
   logic [SW-1:0] k_ff, cnt_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   logic [WORD_BITS-1:0] mx_mag, my_mag;
   logic                 mx_neg, my_neg;
   logic [MW-1:0]        prod_mag;
   logic                 prod_neg;
   logic                 b_neg;
   logic [MW-1:0]        sum_mag;
   logic                 sum_neg;
   logic [MW:0]          shifted, rem_in;
   logic                 ge;
   logic [MW-1:0]        quot_in;
   logic [MW-1:0]        lim;
   logic                 fits_n, fits_d;
   logic signed [WORD_BITS-1:0] enc_n, enc_d;

   assign raw[0] = req_data.a_num[WORD_BITS-1:0];
   assign raw[1] = req_data.a_den[WORD_BITS-1:0];
   assign raw[2] = req_data.b_num[WORD_BITS-1:0];
   assign raw[3] = req_data.b_den[WORD_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_data.cmd;
         for (int i = 0; i < 4; i++) begin
            sgn_ff[i] <= raw[i][WORD_BITS-1];
            mag_ff[i] <= raw[i][WORD_BITS-1] ? (~raw[i] + 1'b1) : raw[i];
         end
      end
   end

   // shared multiplier
   always_comb begin
      unique case (cmd.mul_step)
         MSTEP_N0: begin
            mx_mag = mag_ff[0];
            mx_neg = sgn_ff[0];
            my_mag = (op_ff == CMD_MUL) ? mag_ff[2] : mag_ff[3];
            my_neg = (op_ff == CMD_MUL) ? sgn_ff[2] : sgn_ff[3];
         end
         MSTEP_N1: begin
            mx_mag = mag_ff[2];
            mx_neg = sgn_ff[2];
            my_mag = mag_ff[1];
            my_neg = sgn_ff[1];
         end
         default: begin
            mx_mag = mag_ff[1];
            mx_neg = sgn_ff[1];
            my_mag = (op_ff == CMD_DIV) ? mag_ff[2] : mag_ff[3];
            my_neg = (op_ff == CMD_DIV) ? sgn_ff[2] : sgn_ff[3];
         end
      endcase
      prod_mag = MW'(mx_mag) * MW'(my_mag);
      prod_neg = (prod_mag != '0) && (mx_neg ^ my_neg);
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         unique case (cmd.mul_step)
            MSTEP_N0: begin
               p0_mag_ff <= prod_mag;
               p0_neg_ff <= prod_neg;
            end
            MSTEP_N1: begin
               p1_mag_ff <= prod_mag;
               p1_neg_ff <= prod_neg;
            end
            default: begin
               d_mag_ff <= prod_mag;
               d_neg_ff <= prod_neg;
            end
         endcase
      end
   end

   // numerator combine
   always_comb begin
      b_neg = p1_neg_ff ^ ((op_ff == CMD_SUB) && (p1_mag_ff != '0));
      priority if (p0_neg_ff == b_neg) begin
         sum_mag = p0_mag_ff + p1_mag_ff;
         sum_neg = p0_neg_ff;
      end else if (p0_mag_ff >= p1_mag_ff) begin
         sum_mag = p0_mag_ff - p1_mag_ff;
         sum_neg = p0_neg_ff;
      end else begin
         sum_mag = p1_mag_ff - p0_mag_ff;
         sum_neg = b_neg;
      end
      if (sum_mag == '0) sum_neg = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.combine) begin
         if ((op_ff == CMD_ADD) || (op_ff == CMD_SUB)) begin
            n_mag_ff <= sum_mag;
            n_neg_ff <= sum_neg;
         end else begin
            n_mag_ff <= p0_mag_ff;
            n_neg_ff <= p0_neg_ff;
         end
      end
   end

   // binary GCD, one step a cycle
   always_ff @(posedge clock) begin
      if (cmd.gcd_init) begin
         u_ff <= n_mag_ff;
         v_ff <= d_mag_ff;
         k_ff <= '0;
      end else if (cmd.gcd_step) begin
         priority if (!u_ff[0] && !v_ff[0]) begin
            u_ff <= u_ff >> 1;
            v_ff <= v_ff >> 1;
            k_ff <= k_ff + 1'b1;
         end else if (!u_ff[0]) begin
            u_ff <= u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_ff <= v_ff >> 1;
         end else if (u_ff >= v_ff) begin
            u_ff <= (u_ff - v_ff) >> 1;
         end else begin
            v_ff <= (v_ff - u_ff) >> 1;
         end
      end
      if (cmd.g_load) g_ff <= v_ff << k_ff;
   end

   // restoring divider, one quotient bit a cycle
   always_comb begin
      shifted = {rem_ff[MW-1:0], quot_ff[MW-1]};
      ge      = (shifted >= {1'b0, g_ff});
      rem_in  = ge ? (shifted - {1'b0, g_ff}) : shifted;
      quot_in = {quot_ff[MW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff  <= '0;
         quot_ff <= cmd.div_den ? d_mag_ff : n_mag_ff;
         cnt_ff  <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
         cnt_ff  <= cnt_ff + 1'b1;
         if (stat.div_last) begin
            if (cmd.div_den) qd_ff <= quot_in;
            else             qn_ff <= quot_in;
         end
      end
   end

   assign stat.den_zero = (d_mag_ff == '0);
   assign stat.gcd_done = (u_ff == '0);
   assign stat.div_last = (cnt_ff == SW'(MW - 1));

   // range check and encode
   always_comb begin
      lim    = MW'(1) << (WORD_BITS - 1);
      fits_n = n_neg_ff ? (qn_ff <= lim) : (qn_ff < lim);
      fits_d = d_neg_ff ? (qd_ff <= lim) : (qd_ff < lim);
      enc_n  = n_neg_ff ? (~qn_ff[WORD_BITS-1:0] + 1'b1) : qn_ff[WORD_BITS-1:0];
      enc_d  = d_neg_ff ? (~qd_ff[WORD_BITS-1:0] + 1'b1) : qd_ff[WORD_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         priority if (d_mag_ff == '0) begin
            rsp_ff.res_num <= '0;
            rsp_ff.res_den <= 32'sd1;
            rsp_ff.status  <= STAT_DIV_ZERO;
         end else if (!fits_n || !fits_d) begin
            rsp_ff.res_num <= '0;
            rsp_ff.res_den <= 32'sd1;
            rsp_ff.status  <= STAT_OVERFLOW;
         end else begin
            rsp_ff.res_num <= 32'(enc_n);
            rsp_ff.res_den <= 32'(enc_d);
            rsp_ff.status  <= STAT_OK;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### sv/rau_checker.sv
// rau_checker: port-level assertions for rational_arith_unit, bound below.
// Depends on rau_pkg.
module rau_checker import rau_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transfer accepted but unit not busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STAT_OK || rsp_data.status == STAT_DIV_ZERO ||
                     rsp_data.status == STAT_OVERFLOW))
      else $error("bad status code");

   a_err_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STAT_OK) |->
         (rsp_data.res_num == 32'sd0 && rsp_data.res_den == 32'sd1))
      else $error("error response with nonzero payload");

   a_ok_den: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STAT_OK) |-> (rsp_data.res_den != 32'sd0))
      else $error("zero denominator reported as ok");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

### test/rau_checker.sv
// rau_scoreboard: watches the request and response channels of rational_arith_unit,
// predicts each reduced fraction and compares it field by field. Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_scoreboard import rau_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending
);
   rsp_type expected_q[$];

   function automatic rsp_type reduce_fraction(req_type r);
      logic signed [65:0] n, d;
      logic [65:0]        nm, dm, x, y, t;
      logic signed [66:0] lim;
      rsp_type            o;
      n = 0;
      d = 0;
      case (r.cmd)
         CMD_ADD: begin
            n = 66'(r.a_num) * 66'(r.b_den) + 66'(r.b_num) * 66'(r.a_den);
            d = 66'(r.a_den) * 66'(r.b_den);
         end
         CMD_SUB: begin
            n = 66'(r.a_num) * 66'(r.b_den) - 66'(r.b_num) * 66'(r.a_den);
            d = 66'(r.a_den) * 66'(r.b_den);
         end
         CMD_MUL: begin
            n = 66'(r.a_num) * 66'(r.b_num);
            d = 66'(r.a_den) * 66'(r.b_den);
         end
         default: begin
            n = 66'(r.a_num) * 66'(r.b_den);
            d = 66'(r.a_den) * 66'(r.b_num);
         end
      endcase
      o.res_num = 0;
      o.res_den = 1;
      if (d == 0) begin
         o.status = STAT_DIV_ZERO;
         return o;
      end
      nm = n < 0 ? -n : n;
      dm = d < 0 ? -d : d;
      x = nm;
      y = dm;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      nm = nm / x;
      dm = dm / x;
      n = n < 0 ? -$signed(nm) : $signed(nm);
      d = d < 0 ? -$signed(dm) : $signed(dm);
      lim = 67'sd1 <<< 31;
      if (n >= lim || n < -lim || d >= lim || d < -lim) begin
         o.status = STAT_OVERFLOW;
         return o;
      end
      o.res_num = n[31:0];
      o.res_den = d[31:0];
      o.status = STAT_OK;
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (start && !busy)
            expected_q.push_back(reduce_fraction(req_data));
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               $display("%0t unexpected result transfer", $realtime);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.res_num !== want.res_num)
                  report_mismatch("res_num", rsp_data.res_num, want.res_num);
               if (rsp_data.res_den !== want.res_den)
                  report_mismatch("res_den", rsp_data.res_den, want.res_den);
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            end
         end
      end
      pending <= expected_q.size();
   end
endmodule

### test/tb_rational_arith_unit.sv
// tb_rational_arith_unit: stimulus and verdict for rational_arith_unit.
// Depends on rau_pkg, rational_arith_unit and rau_scoreboard.
`timescale 1ns / 1ps
module tb_rational_arith_unit;
   import rau_pkg::*;

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      fail_count, pending;
   int      sent;

   always #6 clock = ~clock;

   rational_arith_unit dut (.*);
   rau_scoreboard chk (.*);

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 0;
         3: return $urandom_range(0, 1) ? 32'd1 : 32'hffff_ffff;
         4, 5: return 32'($signed($urandom_range(0, 40)) - 20);
         6: return 32'($signed($urandom_range(0, 4000)) - 2000);
         7: return $urandom >> $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   // leaves start high; the caller drops it before idling
   task automatic send(logic [1:0] cmd, logic [31:0] an, logic [31:0] ad,
                       logic [31:0] bn, logic [31:0] bd);
      req_data <= '{cmd, an, ad, bn, bd};
      start <= 1;
      do @(posedge clock); while (busy);
      sent++;
   endtask

   initial begin
      logic [31:0] v[5];
      bit          calm;
      int          idle;
      sent = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int c = 0; c < 4; c++) begin
         send(c[1:0], 1, 2, 1, 3);
         send(c[1:0], 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff, 1);
         send(c[1:0], 0, 32'hffff_ffff, 5, 7);
         send(c[1:0], 3, 0, 5, 7);
         send(c[1:0], 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
      end
      send(CMD_DIV, 4, 6, 0, 9);
      send(CMD_SUB, 5, 7, 5, 7);
      send(CMD_MUL, 6, -4, -10, 15);
      send(CMD_ADD, 32'h8000_0000, 1, 32'h8000_0000, 1);
      start <= 0;
      @(posedge clock);
      wait (pending == 0);
      for (int i = 0; i < 750; i++) begin
         calm = i >= 300 && i < 400;
         idle = 0;
         if (!calm) begin
            while ($urandom_range(0, 99) < 31) idle++;
         end
         if (idle > 0) begin
            start <= 0;
            repeat (idle) @(posedge clock);
         end
         foreach (v[k]) v[k] = pick_value();
         if ($urandom_range(0, 3) == 0) v[4] = $urandom;
         send(2'($urandom_range(0, 3)), v[0], v[1], v[2], v[3]);
      end
      start <= 0;
      @(posedge clock);
      wait (pending == 0);
      repeat (300) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #(12 * 1000000);
      $display("Verification failed");
      $finish;
   end
endmodule
